>>> src/fdss_pkg.sv
// Shared types, constants and the glyph table for the seven-segment driver.
`timescale 1ns / 1ps
`default_nettype none

package fdss_pkg;

  // Converter geometry: magnitude bits shifted in, BCD bits held
  localparam int MAG_W   = 14;
  localparam int BCD_W   = 16;
  localparam int DIGIT_N = 4;
  localparam int STEP_W  = $clog2(MAG_W);

  // Fixed segment patterns, A in bit 7 down to P in bit 0
  localparam logic [7:0] SEG_BLANK = 8'b0000_0000;
  localparam logic [7:0] SEG_OVER  = 8'b1000_0000;
  localparam logic [7:0] SEG_UNDER = 8'b0001_0000;
  localparam logic [7:0] SEG_MINUS = 8'b0000_0010;

  // Decimal display range
  localparam logic signed [15:0] DEC_MAX = 16'sd9999;
  localparam logic signed [15:0] DEC_MIN = -16'sd999;

  // Item kinds
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Register indexes
  localparam logic REG_COMMON_CATHODE = 1'b0;

  // Load sequencer states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_CONV
  } state_t;

  // Converter status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } bcd_stat_t;

  // Hex digit to segment pattern
  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'h0:    g = 8'hFC;
      4'h1:    g = 8'h60;
      4'h2:    g = 8'hDA;
      4'h3:    g = 8'hF2;
      4'h4:    g = 8'h66;
      4'h5:    g = 8'hB6;
      4'h6:    g = 8'hBE;
      4'h7:    g = 8'hE0;
      4'h8:    g = 8'hFE;
      4'h9:    g = 8'hF6;
      4'hA:    g = 8'hEE;
      4'hB:    g = 8'h3E;
      4'hC:    g = 8'h9C;
      4'hD:    g = 8'h7A;
      4'hE:    g = 8'h9E;
      default: g = 8'h8E;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

>>> src/fdss_bcd.sv
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module fdss_bcd
  import fdss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [MAG_W-1:0] bin,
  output bcd_stat_t             stat,
  output logic [BCD_W-1:0]      bcd
);

  logic [MAG_W-1:0]  shreg_r, shreg_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [BCD_W-1:0]  adj;

  // Add 3 to every digit that is 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DIGIT_N; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                 : bcd_r[4*i +: 4];
    end
  end

  // Step control
  always_comb begin
    shreg_nxt = shreg_r;
    bcd_nxt   = bcd_r;
    step_nxt  = step_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      shreg_nxt = bin;
      bcd_nxt   = '0;
      step_nxt  = '0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      shreg_nxt = {shreg_r[MAG_W-2:0], 1'b0};
      bcd_nxt   = {adj[BCD_W-2:0], shreg_r[MAG_W-1]};
      step_nxt  = step_r + 1'b1;
      if (step_r == STEP_W'(MAG_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    shreg_r <= shreg_nxt;
    bcd_r   <= bcd_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign bcd       = bcd_r;

endmodule

`default_nettype wire

>>> src/fdss_cfg.sv
// APB-style configuration register holding the display polarity.
`timescale 1ns / 1ps
`default_nettype none

module fdss_cfg
  import fdss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic             common_cathode
);

  logic cc_r, cc_nxt;
  logic wr_en;

  // Write at the access phase
  assign wr_en = psel && penable && pwrite && pready;

  always_comb begin
    cc_nxt = cc_r;
    if (wr_en && (paddr[2] == REG_COMMON_CATHODE)) begin
      cc_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r <= 1'b1;
    end else begin
      cc_r <= cc_nxt;
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_COMMON_CATHODE) begin
      prdata = {31'd0, cc_r};
    end
  end

  assign pready         = 1'b1;
  assign common_cathode = cc_r;

endmodule

`default_nettype wire

>>> src/four_digit_seven_segment_driver.sv
// Top level: load sequencer, digit pattern store, scan counter and result register.
`timescale 1ns / 1ps
`default_nettype none

// Four-digit multiplexed seven-segment driver. A load transaction (in_mode 0)
// stores four segment patterns; a tick transaction (in_mode 1) advances the
// scan position and returns one result with that digit's segments, a one-hot
// digit enable and the position, polarity set by the common_cathode register
// (address 0). Ticks and hex, overflow and underflow loads need no conversion.
// A decimal load in range goes through the bit-serial shift-and-add-3
// converter, which flags completion before the patterns are stored; no
// transaction is taken meanwhile. Results sit in an output register; any
// input transaction, load or tick, waits until that register is free or
// being emptied.
module four_digit_seven_segment_driver
  import fdss_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_mode,
  input  wire logic signed [15:0] in_value,
  input  wire logic               in_hex_base,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_segments,
  output logic [3:0]              out_digit_enable,
  output logic [1:0]              out_digit_position,
  // configuration port
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [2:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  state_t           state_r, state_nxt;
  logic [7:0]       pat_r [DIGIT_N];
  logic [1:0]       scan_r;
  logic             neg_r;
  logic             out_valid_r;
  logic [7:0]       seg_r;
  logic [3:0]       en_r;
  logic [1:0]       pos_r;

  logic             common_cathode;
  bcd_stat_t        bcd_stat;
  logic [BCD_W-1:0] bcd;
  logic             bcd_start;
  logic             accept;
  logic             acc_load;
  logic             acc_tick;
  logic             over;
  logic             under;
  logic [15:0]      abs_val;
  logic [MAG_W-1:0] mag;
  logic             dec_store;
  logic [1:0]       pos_nxt;
  logic [7:0]       seg_sel;
  logic [3:0]       en_sel;
  logic [3:0]       d [DIGIT_N];
  logic [2:0]       lead_nz;

  // Configuration register
  fdss_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (cfg_psel),
    .penable        (cfg_penable),
    .pwrite         (cfg_pwrite),
    .paddr          (cfg_paddr),
    .pwdata         (cfg_pwdata),
    .prdata         (cfg_prdata),
    .pready         (cfg_pready),
    .common_cathode (common_cathode)
  );

  // Decimal conversion unit
  fdss_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (bcd_start),
    .bin   (mag),
    .stat  (bcd_stat),
    .bcd   (bcd)
  );

  // Input decode
  assign accept   = in_valid && in_ready;
  assign acc_load = accept && (in_mode == MODE_LOAD);
  assign acc_tick = accept && (in_mode == MODE_TICK);
  assign over     = in_value > DEC_MAX;
  assign under    = in_value < DEC_MIN;
  assign abs_val  = in_value[15] ? (~in_value + 16'd1) : in_value;
  assign mag      = abs_val[MAG_W-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (bcd_start) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bcd_stat.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready  = 1'b0;
    bcd_start = 1'b0;
    dec_store = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = !out_valid_r || out_ready;
        bcd_start = in_valid && in_ready && (in_mode == MODE_LOAD) &&
                    !in_hex_base && !over && !under;
      end
      ST_CONV: begin
        dec_store = bcd_stat.done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // BCD digits, thousands first, and leading-zero blanking flags
  always_comb begin
    for (int i = 0; i < DIGIT_N; i++) begin
      d[i] = bcd[BCD_W-1-4*i -: 4];
    end
    lead_nz[0] = (d[0] != 4'd0);
    lead_nz[1] = lead_nz[0] || (d[1] != 4'd0);
    lead_nz[2] = lead_nz[1] || (d[2] != 4'd0);
  end

  // Pattern store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGIT_N; i++) begin
        pat_r[i] <= SEG_BLANK;
      end
    end else if (acc_load && in_hex_base) begin
      for (int i = 0; i < DIGIT_N; i++) begin
        pat_r[i] <= glyph(in_value[15-4*i -: 4]);
      end
    end else if (acc_load && over) begin
      for (int i = 0; i < DIGIT_N; i++) begin
        pat_r[i] <= SEG_OVER;
      end
    end else if (acc_load && under) begin
      for (int i = 0; i < DIGIT_N; i++) begin
        pat_r[i] <= SEG_UNDER;
      end
    end else if (dec_store) begin
      // leftmost digit carries the minus sign for negative values
      pat_r[0] <= neg_r ? SEG_MINUS : (lead_nz[0] ? glyph(d[0]) : SEG_BLANK);
      for (int i = 1; i < DIGIT_N-1; i++) begin
        pat_r[i] <= lead_nz[i] ? glyph(d[i]) : SEG_BLANK;
      end
      pat_r[DIGIT_N-1] <= glyph(d[DIGIT_N-1]);
    end
  end

  // Sign of the value being converted
  always_ff @(posedge clk) begin
    if (bcd_start) begin
      neg_r <= in_value[15];
    end
  end

  // Scan position and result selection with polarity
  assign pos_nxt = scan_r + 2'd1;

  always_comb begin
    seg_sel = pat_r[pos_nxt];
    en_sel  = 4'(1) << pos_nxt;
    if (common_cathode) begin
      en_sel = ~en_sel;
    end else begin
      seg_sel = ~seg_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc_tick) begin
        scan_r      <= pos_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (acc_tick) begin
      seg_r <= seg_sel;
      en_r  <= en_sel;
      pos_r <= pos_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_segments       = seg_r;
  assign out_digit_enable   = en_r;
  assign out_digit_position = pos_r;

endmodule

`default_nettype wire
